[rtl/core/hsv_pkg.sv]
// Shared types and constants for the HSV to RGB color converter.
// Holds the port word types, the stage-to-stage word types and the fixed-point constants.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

    localparam logic [7:0]  UNIT        = 8'd255;
    localparam logic [7:0]  HALF_UNIT   = 8'd127;
    localparam logic [15:0] DEN         = 16'd65280;
    localparam logic [15:0] HALF_DEN    = 16'd32640;
    localparam logic [8:0]  FSCALE      = 9'd256;
    localparam logic [15:0] RECIP       = 16'd32897;
    localparam int          RECIP_SHIFT = 23;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        logic [10:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_word_t;

    typedef struct packed {
        sector_t     sector;
        logic [7:0]  brightness;
        logic [7:0]  fp;
        logic [15:0] fq;
        logic [15:0] ft;
    } factor_t;

    typedef struct packed {
        sector_t     sector;
        logic [7:0]  brightness;
        logic [15:0] xp;
        logic [15:0] xq;
        logic [15:0] xt;
    } product_t;

    typedef struct packed {
        sector_t    sector;
        logic [7:0] brightness;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } pqt_t;

endpackage

`default_nettype wire

[rtl/core/hsv_factor.sv]
// First pipeline stage: sector decode and the three scale factors 1-s, 1-s*f, 1-s*(1-f).
// Uses the word types and constants of hsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv_factor (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pixel_valid,
    output logic                   pixel_stall,
    input  wire hsv_pkg::hsv_word_t pixel,
    output logic                   fac_valid,
    input  wire logic              fac_stall,
    output hsv_pkg::factor_t       fac
);

    logic             valid_reg;
    hsv_pkg::factor_t fac_reg;
    hsv_pkg::factor_t fac_next;
    logic [7:0]       frac;
    logic [8:0]       inv_frac;
    logic [15:0]      s_frac;
    logic [15:0]      s_inv_frac;

    assign pixel_stall = valid_reg && fac_stall;
    assign fac_valid   = valid_reg;
    assign fac         = fac_reg;

    always_comb
    begin
        frac       = pixel.hue[7:0];
        inv_frac   = hsv_pkg::FSCALE - {1'b0, frac};
        s_frac     = 16'(pixel.saturation) * 16'(frac);
        s_inv_frac = 16'(pixel.saturation) * 16'(inv_frac);

        case (pixel.hue[10:8])
            3'd0:    fac_next.sector = hsv_pkg::SEC_RED;
            3'd1:    fac_next.sector = hsv_pkg::SEC_YELLOW;
            3'd2:    fac_next.sector = hsv_pkg::SEC_GREEN;
            3'd3:    fac_next.sector = hsv_pkg::SEC_CYAN;
            3'd4:    fac_next.sector = hsv_pkg::SEC_BLUE;
            3'd5:    fac_next.sector = hsv_pkg::SEC_MAGENTA;
            3'd6:    fac_next.sector = hsv_pkg::SEC_RED;
            3'd7:    fac_next.sector = hsv_pkg::SEC_YELLOW;
            default: fac_next.sector = hsv_pkg::SEC_RED;
        endcase

        fac_next.brightness = pixel.brightness;
        fac_next.fp         = hsv_pkg::UNIT - pixel.saturation;
        fac_next.fq         = hsv_pkg::DEN - s_frac;
        fac_next.ft         = hsv_pkg::DEN - s_inv_frac;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!pixel_stall)
        begin
            valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!pixel_stall && pixel_valid)
        begin
            fac_reg <= fac_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hsv_product.sv]
// Second pipeline stage: brightness times each factor plus the rounding offset.
// Uses the stage word types and constants of hsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv_product (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fac_valid,
    output logic                  fac_stall,
    input  wire hsv_pkg::factor_t fac,
    output logic                  prod_valid,
    input  wire logic             prod_stall,
    output hsv_pkg::product_t     prod
);

    logic              valid_reg;
    hsv_pkg::product_t prod_reg;
    hsv_pkg::product_t prod_next;
    logic [15:0]       mul_p;
    logic [23:0]       sum_q;
    logic [23:0]       sum_t;

    assign fac_stall  = valid_reg && prod_stall;
    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

    // The q and t sums are divided by 256 here; the remaining division by 255 follows.
    always_comb
    begin
        mul_p = 16'(fac.brightness) * 16'(fac.fp);
        sum_q = 24'(fac.brightness) * 24'(fac.fq) + 24'(hsv_pkg::HALF_DEN);
        sum_t = 24'(fac.brightness) * 24'(fac.ft) + 24'(hsv_pkg::HALF_DEN);

        prod_next.sector     = fac.sector;
        prod_next.brightness = fac.brightness;
        prod_next.xp         = mul_p + 16'(hsv_pkg::HALF_UNIT);
        prod_next.xq         = sum_q[23:8];
        prod_next.xt         = sum_t[23:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!fac_stall)
        begin
            valid_reg <= fac_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!fac_stall && fac_valid)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hsv_div255.sv]
// Third pipeline stage: exact division of the three sums by 255 through a reciprocal multiply.
// Uses the stage word types and constants of hsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv_div255 (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              prod_valid,
    output logic                   prod_stall,
    input  wire hsv_pkg::product_t prod,
    output logic                   pqt_valid,
    input  wire logic              pqt_stall,
    output hsv_pkg::pqt_t          pqt
);

    logic          valid_reg;
    hsv_pkg::pqt_t pqt_reg;
    hsv_pkg::pqt_t pqt_next;

    // The reciprocal 32897 / 2^23 gives the exact floor of x / 255 for every x up to 65279.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [31:0] full;
        full = 32'(x) * 32'(hsv_pkg::RECIP);
        return full[hsv_pkg::RECIP_SHIFT +: 8];
    endfunction

    assign prod_stall = valid_reg && pqt_stall;
    assign pqt_valid  = valid_reg;
    assign pqt        = pqt_reg;

    always_comb
    begin
        pqt_next.sector     = prod.sector;
        pqt_next.brightness = prod.brightness;
        pqt_next.p          = div255(prod.xp);
        pqt_next.q          = div255(prod.xq);
        pqt_next.t          = div255(prod.xt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!prod_stall)
        begin
            valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!prod_stall && prod_valid)
        begin
            pqt_reg <= pqt_next;
        end
    end

    a_within_brightness: assert property (@(posedge clk) disable iff (!rst_n)
        pqt_valid |-> (pqt.p <= pqt.brightness) && (pqt.q <= pqt.brightness)
                      && (pqt.t <= pqt.brightness))
        else $error("p, q or t exceeds brightness");

    a_p_lowest: assert property (@(posedge clk) disable iff (!rst_n)
        pqt_valid |-> (pqt.p <= pqt.q) && (pqt.p <= pqt.t))
        else $error("p is not the smallest of p, q and t");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pqt_valid && pqt_stall |=> pqt_valid && $stable(pqt))
        else $error("stage word changed while stalled");

endmodule

`default_nettype wire

[rtl/core/hsv_to_rgb_converter_core.sv]
// Top level of the HSV to RGB color converter: three arithmetic stages and the channel select.
// Instantiates hsv_factor, hsv_product and hsv_div255; uses hsv_pkg.
//
// One pixel word enters and one color word leaves per clock, unless a stall holds the pipeline.
// The four register stages are the factor multiplies, the brightness multiplies, the reciprocal
// multiplies for the division by 255, and the six-way sector select into the output register.
// Each stage holds its word while its successor stalls and takes a new word into any empty slot,
// so a stall on the color side reaches the pixel side only once the pipeline is full.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pixel_valid,
    output logic                    pixel_stall,
    input  wire hsv_pkg::hsv_word_t pixel,
    output logic                    color_valid,
    input  wire logic               color_stall,
    output hsv_pkg::rgb_word_t      color
);

    logic               fac_valid;
    logic               fac_stall;
    hsv_pkg::factor_t   fac;
    logic               prod_valid;
    logic               prod_stall;
    hsv_pkg::product_t  prod;
    logic               pqt_valid;
    logic               pqt_stall;
    hsv_pkg::pqt_t      pqt;
    logic               valid_reg;
    hsv_pkg::rgb_word_t color_reg;
    hsv_pkg::rgb_word_t color_next;

    hsv_factor u_factor (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .fac_valid   (fac_valid),
        .fac_stall   (fac_stall),
        .fac         (fac)
    );

    hsv_product u_product (
        .clk        (clk),
        .rst_n      (rst_n),
        .fac_valid  (fac_valid),
        .fac_stall  (fac_stall),
        .fac        (fac),
        .prod_valid (prod_valid),
        .prod_stall (prod_stall),
        .prod       (prod)
    );

    hsv_div255 u_div255 (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_stall (prod_stall),
        .prod       (prod),
        .pqt_valid  (pqt_valid),
        .pqt_stall  (pqt_stall),
        .pqt        (pqt)
    );

    assign pqt_stall   = valid_reg && color_stall;
    assign color_valid = valid_reg;
    assign color       = color_reg;

    always_comb
    begin
        case (pqt.sector)
            hsv_pkg::SEC_RED:
            begin
                color_next.red   = pqt.brightness;
                color_next.green = pqt.t;
                color_next.blue  = pqt.p;
            end
            hsv_pkg::SEC_YELLOW:
            begin
                color_next.red   = pqt.q;
                color_next.green = pqt.brightness;
                color_next.blue  = pqt.p;
            end
            hsv_pkg::SEC_GREEN:
            begin
                color_next.red   = pqt.p;
                color_next.green = pqt.brightness;
                color_next.blue  = pqt.t;
            end
            hsv_pkg::SEC_CYAN:
            begin
                color_next.red   = pqt.p;
                color_next.green = pqt.q;
                color_next.blue  = pqt.brightness;
            end
            hsv_pkg::SEC_BLUE:
            begin
                color_next.red   = pqt.t;
                color_next.green = pqt.p;
                color_next.blue  = pqt.brightness;
            end
            default:
            begin
                color_next.red   = pqt.brightness;
                color_next.green = pqt.p;
                color_next.blue  = pqt.q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!pqt_stall)
        begin
            valid_reg <= pqt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!pqt_stall && pqt_valid)
        begin
            color_reg <= color_next;
        end
    end

endmodule

`default_nettype wire
